@@ hdl/cuckoo_hash_table_core_assert.svh @@
// ----------------------------------------------------------------------------
// Cuckoo hash table assertion macros
// Shorthand for clocked assertions on clk, disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef CUCKOO_HASH_TABLE_CORE_ASSERT_SVH
`define CUCKOO_HASH_TABLE_CORE_ASSERT_SVH

// Same-cycle implication.
`define CHT_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define CHT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/cht_pkg.sv @@
// ----------------------------------------------------------------------------
// Cuckoo hash table package
// Transfer types, command and status codes, FNV-1a constants.
// ----------------------------------------------------------------------------
package cht_pkg;

  localparam int KEY_BITS = 32;

  localparam logic [63:0] FNV_BASIS = 64'hCBF2_9CE4_8422_2325;
  localparam logic [63:0] PRIME_ONE = 64'h0000_0100_0000_01B3;
  localparam logic [63:0] PRIME_TWO = 64'h0000_0000_0100_0193;

  typedef enum logic [1:0] {
    CMD_LOOKUP = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_REMOVE = 2'd2
  } cmd_t;

  typedef enum logic [2:0] {
    ST_INSERTED   = 3'd0,
    ST_UPDATED    = 3'd1,
    ST_FOUND      = 3'd2,
    ST_NOT_FOUND  = 3'd3,
    ST_KICK_LIMIT = 3'd4
  } status_t;

  typedef struct packed {
    logic        [1:0]  command;
    logic signed [31:0] key;
    logic        [31:0] value;
  } in_item_t;

  typedef struct packed {
    logic        [2:0]  status;
    logic               found;
    logic        [31:0] data_out;
    logic signed [31:0] homeless_key;
    logic        [31:0] homeless_value;
    logic        [8:0]  occupancy;
  } out_item_t;

endpackage

@@ hdl/cht_hash.sv @@
// ----------------------------------------------------------------------------
// Cuckoo hash slot hash unit
// One-round FNV-1a on the low slot bits; prime picked per use. Registered out.
// ----------------------------------------------------------------------------
module cht_hash #(
  parameter int AW = 8
) (
  input  logic                          clk,
  input  logic [cht_pkg::KEY_BITS-1:0]  key,
  input  logic                          first,
  output logic [AW-1:0]                 slot
);

  // Low AW bits of the 64-bit product depend only on the low AW bits of
  // each operand; sign extension of the key never reaches them.
  logic [AW-1:0] mixed;
  logic [AW-1:0] prime;
  logic [AW-1:0] product;

  assign mixed   = cht_pkg::FNV_BASIS[AW-1:0] ^ key[AW-1:0];
  assign prime   = first ? cht_pkg::PRIME_ONE[AW-1:0] : cht_pkg::PRIME_TWO[AW-1:0];
  assign product = mixed * prime;

  always_ff @(posedge clk) begin
    slot <= product;
  end

endmodule

@@ hdl/cht_ram.sv @@
// ----------------------------------------------------------------------------
// Cuckoo hash slot memory
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module cht_ram #(
  parameter int AW = 8,
  parameter int W  = 66
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [W-1:0]  wr_data,
  input  logic [AW-1:0] rd_addr,
  output logic [W-1:0]  rd_data
);

  logic [W-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

@@ hdl/cuckoo_hash_table_core.sv @@
// ----------------------------------------------------------------------------
// Cuckoo hash table core
// Two-hash cuckoo table: lookup, insert or update, remove, with eviction chain.
// ----------------------------------------------------------------------------
//
//   channel  direction  handshake              payload
//   in       input      in_valid / in_ready    in_item  (command, key, value)
//   out      output     out_valid / out_ready  out_item (status ... occupancy)
//   cfg      input      cfg_wr_en              cfg_wr_data (kick_limit)
//
// Pacing: in_ready stays low from one transfer until the item has left S_DONE,
//   for every command; an insert of a new key also walks the eviction chain. The
//   pace is set by the shared hash unit and the slot memory's one read port.
// Reset: a clearing pass writes every slot invalid, with in_ready low; cfg
//   writes are taken throughout.
// Stalls: the result sits in an output register; a new item is taken while it
//   waits, and the core holds its next result until that register drains.
// ----------------------------------------------------------------------------
module cuckoo_hash_table_core #(
  parameter int LOG2_SLOTS = 8,
  parameter int DATA_BITS  = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  cht_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_ready,
  output cht_pkg::out_item_t out_item,
  input  logic               cfg_wr_en,
  input  logic [6:0]         cfg_wr_data
);

  localparam int AW = LOG2_SLOTS;
  localparam int CW = LOG2_SLOTS + 1;
  localparam logic [AW-1:0] LAST_SLOT = '1;

  // One memory word per slot.
  typedef struct packed {
    logic                 valid;
    logic                 first;   // resident sits in its first-hash slot
    logic [31:0]          key;
    logic [DATA_BITS-1:0] data;
  } slot_t;

  localparam int SW = $bits(slot_t);

  typedef enum logic [10:0] {
    S_CLEAR = 11'b000_0000_0001,
    S_IDLE  = 11'b000_0000_0010,
    S_HASH1 = 11'b000_0000_0100,
    S_HASH2 = 11'b000_0000_1000,
    S_CHK1  = 11'b000_0001_0000,
    S_CHK2  = 11'b000_0010_0000,
    S_KHASH = 11'b000_0100_0000,
    S_KREAD = 11'b000_1000_0000,
    S_KLOAD = 11'b001_0000_0000,
    S_PLACE = 11'b010_0000_0000,
    S_DONE  = 11'b100_0000_0000
  } state_t;

  state_t               state;
  state_t               state_next;
  logic [AW-1:0]        clr_idx;
  logic [1:0]           cmd;
  logic [31:0]          cur_key;     // key in hand (new item or evicted one)
  logic [DATA_BITS-1:0] cur_data;
  logic                 cur_first;   // slot kind the key in hand is headed for
  logic [AW-1:0]        ha;
  logic [AW-1:0]        hb;
  logic [AW-1:0]        idx;         // slot under test in the eviction chain
  slot_t                slot_a;      // first-hash slot contents
  slot_t                slot_q;      // slot under test
  logic [6:0]           kicks;
  logic [6:0]           kick_limit;
  logic [CW-1:0]        entry_count;
  cht_pkg::out_item_t   res;
  cht_pkg::out_item_t   res_out;     // res with the current occupancy

  // Shared hash unit and slot memory.
  logic          hash_first;
  logic [AW-1:0] hash_slot;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  slot_t         wr_word;
  logic [SW-1:0] rd_word;
  slot_t         rd_slot;

  cht_hash #(.AW(AW)) u_hash (
    .clk   (clk),
    .key   (cur_key),
    .first (hash_first),
    .slot  (hash_slot)
  );

  // The hash output register doubles as the read address: ha in S_HASH2,
  // hb in S_CHK1, the eviction target in S_KREAD.
  cht_ram #(.AW(AW), .W(SW)) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (SW'(wr_word)),
    .rd_addr (hash_slot),
    .rd_data (rd_word)
  );

  assign rd_slot = slot_t'(rd_word);

  // Probe results in S_CHK2: slot_a holds the first slot, rd_slot the second.
  logic          hit_a;
  logic          hit_b;
  logic          hit;
  logic [AW-1:0] hit_pos;
  slot_t         hit_entry;
  slot_t         new_entry;
  logic          chain_full;

  assign hit_a      = slot_a.valid && (slot_a.key == cur_key);
  assign hit_b      = rd_slot.valid && (rd_slot.key == cur_key);
  assign hit        = hit_a || hit_b;
  assign hit_pos    = hit_a ? ha : hb;
  assign hit_entry  = hit_a ? slot_a : rd_slot;
  assign new_entry  = '{valid: 1'b1, first: cur_first, key: cur_key, data: cur_data};
  assign chain_full = kicks >= kick_limit;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    res_out           = res;
    res_out.occupancy = 9'(entry_count);
  end

  always_comb begin
    state_next = state;
    hash_first = 1'b1;
    wr_en      = 1'b0;
    wr_addr    = idx;
    wr_word    = new_entry;
    case (state)
      S_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_idx;
        wr_word = '0;
        if (clr_idx == LAST_SLOT) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_HASH1;
        end
      end
      S_HASH1: begin
        state_next = S_HASH2;
      end
      S_HASH2: begin
        hash_first = 1'b0;
        state_next = S_CHK1;
      end
      S_CHK1: begin
        state_next = S_CHK2;
      end
      S_CHK2: begin
        state_next = S_DONE;
        wr_addr    = hit_pos;
        if (cmd == cht_pkg::CMD_REMOVE && hit) begin
          wr_en         = 1'b1;
          wr_word       = hit_entry;
          wr_word.valid = 1'b0;
        end else if (cmd == cht_pkg::CMD_INSERT) begin
          if (hit) begin
            wr_en        = 1'b1;
            wr_word      = hit_entry;
            wr_word.data = cur_data;
          end else begin
            state_next = S_PLACE;
          end
        end
      end
      S_KHASH: begin
        hash_first = cur_first;
        state_next = S_KREAD;
      end
      S_KREAD: begin
        state_next = S_KLOAD;
      end
      S_KLOAD: begin
        state_next = S_PLACE;
      end
      S_PLACE: begin
        // Free slot: settle here. Taken: evict unless the chain is spent.
        if (!slot_q.valid) begin
          wr_en      = 1'b1;
          state_next = S_DONE;
        end else if (chain_full) begin
          state_next = S_DONE;
        end else begin
          wr_en      = 1'b1;
          state_next = S_KHASH;
        end
      end
      S_DONE: begin
        if (!out_valid || out_ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLEAR;
      clr_idx     <= '0;
      kicks       <= '0;
      kick_limit  <= 7'd16;
      entry_count <= '0;
      out_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_wr_en) begin
        kick_limit <= cfg_wr_data;
      end
      // Load a finished result, or drop valid once the result is taken.
      if (state == S_DONE && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr_idx <= clr_idx + AW'(1);
        end
        S_IDLE: begin
          if (in_valid) begin
            cmd       <= in_item.command;
            cur_key   <= in_item.key;
            cur_data  <= DATA_BITS'(in_item.value);
            cur_first <= 1'b1;
            kicks     <= '0;
            res       <= '{status: 3'(cht_pkg::ST_NOT_FOUND), default: '0};
          end
        end
        S_HASH2: begin
          ha <= hash_slot;
        end
        S_CHK1: begin
          hb     <= hash_slot;
          slot_a <= rd_slot;
        end
        S_CHK2: begin
          case (cmd)
            cht_pkg::CMD_LOOKUP: begin
              if (hit) begin
                res.status   <= cht_pkg::ST_FOUND;
                res.found    <= 1'b1;
                res.data_out <= 32'(hit_entry.data);
              end
            end
            cht_pkg::CMD_REMOVE: begin
              if (hit) begin
                res.status  <= cht_pkg::ST_FOUND;
                res.found   <= 1'b1;
                entry_count <= entry_count - CW'(1);
              end
            end
            cht_pkg::CMD_INSERT: begin
              if (hit) begin
                res.status <= cht_pkg::ST_UPDATED;
                res.found  <= 1'b1;
              end else begin
                slot_q <= slot_a;
                idx    <= ha;
              end
            end
            default: begin
            end
          endcase
        end
        S_KREAD: begin
          idx <= hash_slot;
        end
        S_KLOAD: begin
          slot_q <= rd_slot;
        end
        S_PLACE: begin
          if (!slot_q.valid) begin
            res.status  <= cht_pkg::ST_INSERTED;
            entry_count <= entry_count + CW'(1);
          end else if (chain_full) begin
            res.status         <= cht_pkg::ST_KICK_LIMIT;
            res.homeless_key   <= cur_key;
            res.homeless_value <= 32'(cur_data);
          end else begin
            // Resident moves on, with its value, toward its other slot.
            cur_key   <= slot_q.key;
            cur_data  <= slot_q.data;
            cur_first <= !slot_q.first;
            kicks     <= kicks + 7'd1;
          end
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_item <= res_out;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

@@ hdl/cht_checker.sv @@
// ----------------------------------------------------------------------------
// Cuckoo hash table port checker
// Watches the top-level ports; bound onto every core instance.
// ----------------------------------------------------------------------------
`include "cuckoo_hash_table_core_assert.svh"

module cht_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input cht_pkg::out_item_t out_item
);

  logic out_stall;
  logic in_xfer;
  logic found_exp;
  logic homeless_ok;

  assign out_stall   = out_valid && !out_ready;
  assign in_xfer     = in_valid && in_ready;
  assign found_exp   = (out_item.status == cht_pkg::ST_UPDATED) ||
                       (out_item.status == cht_pkg::ST_FOUND);
  assign homeless_ok = (out_item.status == cht_pkg::ST_KICK_LIMIT) ||
                       ((out_item.homeless_key == '0) && (out_item.homeless_value == '0));

  `CHT_ASSERT_NEXT(a_out_hold, out_stall, out_valid && $stable(out_item), "stalled result moved")

  `CHT_ASSERT_NEXT(a_busy_after_take, in_xfer, !in_ready, "ready held after input transfer")

  `CHT_ASSERT_SAME(a_found_status, out_valid, out_item.found == found_exp, "found vs status")

  `CHT_ASSERT_SAME(a_homeless_clear, out_valid, homeless_ok, "homeless set without kick limit")

endmodule

bind cuckoo_hash_table_core cht_checker u_cht_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_item  (out_item)
);
